/* design/avi_ce_pkg.sv */
package avi_ce_pkg;

  localparam int unsigned HeaderBytesDefault = 224;

  localparam logic [23:0] MaxFrameReset = 24'd131072;

  localparam logic [31:0] RiffTag = 32'h5249_4646;
  localparam logic [31:0] AviTag = 32'h4156_4920;
  localparam logic [31:0] VideoTag = 32'h3030_6463;
  localparam logic [31:0] DefaultPeriod = 32'd100000;

  localparam logic [31:0] PeriodBase = 32'd32;
  localparam logic [31:0] TotalBase = 32'd48;
  localparam logic [31:0] WidthBase = 32'd64;
  localparam logic [31:0] HeightBase = 32'd68;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindHeader = 2'd1;
  localparam logic [1:0] KindError = 2'd2;
  localparam logic [1:0] KindEmpty = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_item_t;

endpackage

/* design/avi_ce_if.sv */
interface avi_ce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface avi_ce_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        frame_last;
  logic [23:0] frame_length;
  logic [31:0] frame_number;
  logic [31:0] frame_period_us;
  logic [31:0] frame_total;
  logic [31:0] picture_width;
  logic [31:0] picture_height;

  modport source (
    output valid, output result_kind, output payload_byte, output frame_last,
    output frame_length, output frame_number, output frame_period_us,
    output frame_total, output picture_width, output picture_height,
    input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input frame_last,
    input frame_length, input frame_number, input frame_period_us,
    input frame_total, input picture_width, input picture_height,
    output ready
  );
endinterface

interface avi_ce_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] max_frame_bytes;

  modport source (output valid, output max_frame_bytes, input ready);
  modport sink (input valid, input max_frame_bytes, output ready);
endinterface

/* design/avi_video_chunk_extractor_unit.sv */
// A byte is taken into the input register, and its item into the result register.
// Throughput: one byte per cycle while the result side is ready; bytes that
// give no item still pass through the input register.
// Reset (rst_ni low, asynchronous): parser back to the header phase, counts
// and header words cleared, frame size limit back to 131072, no item pending.
module avi_video_chunk_extractor_unit
  import avi_ce_pkg::*;
#(
  parameter int unsigned HeaderBytes = HeaderBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  avi_ce_byte_if.sink     byte_i,
  avi_ce_cfg_if.sink      cfg_i,
  avi_ce_result_if.source result_o
);

  byte_item_t item;
  logic       advance;

  avi_ce_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .item_o    (item)
  );

  avi_ce_parser #(
    .HeaderBytes (HeaderBytes)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .advance_o (advance),
    .cfg_i     (cfg_i),
    .result_o  (result_o)
  );

endmodule

/* design/avi_ce_in_reg.sv */
module avi_ce_in_reg
  import avi_ce_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  avi_ce_byte_if.sink     byte_i,
  input  logic            advance_i,
  output byte_item_t      item_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  assign byte_i.ready = !valid_q || advance_i;
  assign take = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= byte_i.stream_byte;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data = data_q;

endmodule

/* design/avi_ce_parser.sv */
module avi_ce_parser
  import avi_ce_pkg::*;
#(
  parameter int unsigned HeaderBytes = HeaderBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  byte_item_t      item_i,
  output logic            advance_o,
  avi_ce_cfg_if.sink      cfg_i,
  avi_ce_result_if.source result_o
);

  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhChunk = 3'd1;
  localparam logic [2:0] PhData = 3'd2;
  localparam logic [2:0] PhSkip = 3'd3;
  localparam logic [2:0] PhPad = 3'd4;
  localparam logic [2:0] PhHalt = 3'd5;

  localparam logic [31:0] HeaderLast = 32'(HeaderBytes - 1);

  function automatic logic [31:0] lane_or(input logic [31:0] word, input logic [31:0] pos,
                                          input logic [31:0] base, input logic [7:0] b);
    logic [31:0] r;
    logic [31:0] off;
    r = word;
    off = pos - base;
    if (pos >= base && off < 32'd4) begin
      r[{off[1:0], 3'b000} +: 8] = word[{off[1:0], 3'b000} +: 8] | b;
    end
    return r;
  endfunction

  logic [2:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] size_q, size_d;
  logic        magic_q, magic_d;
  logic [31:0] period_q, period_d;
  logic [31:0] total_q, total_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [31:0] frames_q, frames_d;
  logic [23:0] max_q;

  logic        res_valid_q;
  logic [1:0]  res_kind_q, res_kind_d;
  logic [7:0]  res_byte_q, res_byte_d;
  logic        res_last_q, res_last_d;
  logic [23:0] res_len_q, res_len_d;
  logic [31:0] res_num_q;
  logic        res_hdr_q, res_hdr_d;
  logic        emit;
  logic        step;
  logic [7:0]  b;
  logic [32:0] pos_inc;

  assign advance_o = !res_valid_q || result_o.ready;
  assign step = item_i.valid && advance_o;
  assign b = item_i.data;
  assign pos_inc = {1'b0, pos_q} + 33'd1;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    phase_d = phase_q;
    pos_d = pos_q;
    tag_d = tag_q;
    size_d = size_q;
    magic_d = magic_q;
    period_d = period_q;
    total_d = total_q;
    width_d = width_q;
    height_d = height_q;
    frames_d = frames_q;
    emit = 1'b0;
    res_kind_d = KindData;
    res_byte_d = 8'd0;
    res_last_d = 1'b0;
    res_len_d = 24'd0;
    res_hdr_d = 1'b1;
    case (phase_q)
      PhHeader: begin
        if (pos_q < 32'd4 && b != RiffTag[{~pos_q[1:0], 3'b000} +: 8]) begin
          magic_d = 1'b0;
        end
        if (pos_q >= 32'd8 && pos_q < 32'd12 && b != AviTag[{~pos_q[1:0], 3'b000} +: 8]) begin
          magic_d = 1'b0;
        end
        period_d = lane_or(period_q, pos_q, PeriodBase, b);
        total_d = lane_or(total_q, pos_q, TotalBase, b);
        width_d = lane_or(width_q, pos_q, WidthBase, b);
        height_d = lane_or(height_q, pos_q, HeightBase, b);
        if (pos_q >= HeaderLast) begin
          pos_d = 32'd0;
          emit = 1'b1;
          if (!magic_d) begin
            phase_d = PhHalt;
            res_kind_d = KindError;
            res_hdr_d = 1'b0;
          end else begin
            if (period_d == 32'd0) begin
              period_d = DefaultPeriod;
            end
            phase_d = PhChunk;
            res_kind_d = KindHeader;
          end
        end else begin
          pos_d = pos_inc[31:0];
        end
      end
      PhChunk: begin
        if (pos_q < 32'd4) begin
          tag_d = {tag_q[23:0], b};
        end else begin
          size_d = lane_or((pos_q == 32'd4) ? 32'd0 : size_q, pos_q, 32'd4, b);
        end
        if (pos_q < 32'd7) begin
          pos_d = pos_inc[31:0];
        end else begin
          pos_d = 32'd0;
          if (tag_q == VideoTag && size_d <= {8'd0, max_q}) begin
            if (size_d == 32'd0) begin
              // zero-size frame: one empty-frame item
              emit = 1'b1;
              res_kind_d = KindEmpty;
              res_last_d = 1'b1;
              frames_d = frames_q + 32'd1;
              phase_d = PhChunk;
            end else begin
              phase_d = PhData;
            end
          end else if (size_d == 32'd0) begin
            phase_d = PhChunk;
          end else begin
            phase_d = PhSkip;
          end
        end
      end
      PhData: begin
        emit = 1'b1;
        res_kind_d = KindData;
        res_byte_d = b;
        res_len_d = size_q[23:0];
        res_last_d = (pos_inc == {1'b0, size_q});
        if (res_last_d) begin
          frames_d = frames_q + 32'd1;
          pos_d = 32'd0;
          phase_d = size_q[0] ? PhPad : PhChunk;
        end else begin
          pos_d = pos_inc[31:0];
        end
      end
      PhSkip: begin
        if (pos_inc >= {1'b0, size_q}) begin
          pos_d = 32'd0;
          phase_d = size_q[0] ? PhPad : PhChunk;
        end else begin
          pos_d = pos_inc[31:0];
        end
      end
      PhPad: begin
        pos_d = 32'd0;
        phase_d = PhChunk;
      end
      default: begin
        // halted: drop every byte
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q <= 32'd0;
      tag_q <= 32'd0;
      size_q <= 32'd0;
      magic_q <= 1'b1;
      period_q <= 32'd0;
      total_q <= 32'd0;
      width_q <= 32'd0;
      height_q <= 32'd0;
      frames_q <= 32'd0;
    end else if (step) begin
      phase_q <= phase_d;
      pos_q <= pos_d;
      tag_q <= tag_d;
      size_q <= size_d;
      magic_q <= magic_d;
      period_q <= period_d;
      total_q <= total_d;
      width_q <= width_d;
      height_q <= height_d;
      frames_q <= frames_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxFrameReset;
    end else if (cfg_i.valid) begin
      max_q <= cfg_i.max_frame_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance_o) begin
      res_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_kind_q <= res_kind_d;
      res_byte_q <= res_byte_d;
      res_last_q <= res_last_d;
      res_len_q <= res_len_d;
      res_num_q <= frames_q;
      res_hdr_q <= res_hdr_d;
    end
  end

  // header words are settled before any item that carries them leaves
  assign result_o.valid = res_valid_q;
  assign result_o.result_kind = res_kind_q;
  assign result_o.payload_byte = res_byte_q;
  assign result_o.frame_last = res_last_q;
  assign result_o.frame_length = res_len_q;
  assign result_o.frame_number = res_num_q;
  assign result_o.frame_period_us = res_hdr_q ? period_q : 32'd0;
  assign result_o.frame_total = res_hdr_q ? total_q : 32'd0;
  assign result_o.picture_width = res_hdr_q ? width_q : 32'd0;
  assign result_o.picture_height = res_hdr_q ? height_q : 32'd0;

`ifndef NO_ASSERTIONS
  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_kind_q == KindError |-> phase_q == PhHalt)
    else $error("format error item without halted parser");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalt && !res_valid_q |=> !res_valid_q)
    else $error("item produced after halt");

  a_last_leaves_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit && res_kind_d == KindData && res_last_d |-> phase_d != PhData)
    else $error("frame end did not leave data phase");

  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step && emit && res_last_d) |=> $stable(frames_q))
    else $error("frame count moved without a frame end");

  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_kind_q == KindHeader |-> period_q != 32'd0)
    else $error("header item with zero frame period");
`endif

endmodule

/* test/avi_video_chunk_extractor_unit_test.sv */
`timescale 1ns / 1ps

module avi_video_chunk_extractor_unit_test;
  import avi_ce_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 8;
  localparam logic [23:0] MaxFrameTop = 24'hFF_FFFF;

  localparam logic [31:0] AudioTag = 32'h3031_7762;
  localparam logic [31:0] IndexTag = 32'h6964_7831;
  localparam logic [31:0] JunkTag = 32'h4A55_4E4B;
  localparam logic [31:0] RawVideoTag = 32'h3030_6462;

  typedef enum logic [2:0] {
    PhHeader,
    PhChunkHead,
    PhData,
    PhSkip,
    PhPad,
    PhHalt
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [23:0] length;
    logic [31:0] number;
    logic [31:0] period;
    logic [31:0] total;
    logic [31:0] width;
    logic [31:0] height;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  avi_ce_byte_if   byte_if ();
  avi_ce_cfg_if    cfg_if ();
  avi_ce_result_if result_if ();

  avi_video_chunk_extractor_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Parser state as the block should hold it
  parse_phase_e ph_q      = PhHeader;
  logic [31:0]  pos_q     = '0;
  logic [31:0]  tag_q     = '0;
  logic [31:0]  size_q    = '0;
  logic         magic_q   = 1'b1;
  logic [31:0]  period_q  = '0;
  logic [31:0]  total_q   = '0;
  logic [31:0]  width_q   = '0;
  logic [31:0]  height_q  = '0;
  logic [31:0]  frames_q  = '0;
  logic [23:0]  max_q     = MaxFrameReset;

  frame_result_t pending_results[$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   burst_left = 0;

  function automatic frame_result_t stamp_result(input logic [1:0] kind, input logic [7:0] data,
                                                 input logic last, input logic [23:0] length);
    frame_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.last   = last;
    r.length = length;
    r.number = frames_q;
    r.period = period_q;
    r.total  = total_q;
    r.width  = width_q;
    r.height = height_q;
    return r;
  endfunction

  function automatic void finish_chunk_body();
    pos_q = '0;
    ph_q  = size_q[0] ? PhPad : PhChunkHead;
  endfunction

  function automatic void parse_stream_byte(input logic [7:0] b);
    logic [31:0]   pos;
    frame_result_t r;
    logic          last;
    pos = pos_q;
    case (ph_q)
      PhHeader: begin
        if (pos < 4 && b != RiffTag[31 - 8 * pos -: 8]) magic_q = 1'b0;
        if (pos >= 8 && pos < 12 && b != AviTag[31 - 8 * (pos - 8) -: 8]) magic_q = 1'b0;
        if (pos >= PeriodBase && pos < PeriodBase + 4) period_q[8 * (pos - PeriodBase) +: 8] = b;
        if (pos >= TotalBase && pos < TotalBase + 4) total_q[8 * (pos - TotalBase) +: 8] = b;
        if (pos >= WidthBase && pos < WidthBase + 4) width_q[8 * (pos - WidthBase) +: 8] = b;
        if (pos >= HeightBase && pos < HeightBase + 4) height_q[8 * (pos - HeightBase) +: 8] = b;
        if (pos + 1 < HeaderBytesDefault) begin
          pos_q = pos + 1;
        end else begin
          pos_q = '0;
          if (!magic_q) begin
            ph_q = PhHalt;
            r = '0;
            r.kind = KindError;
            pending_results.push_back(r);
          end else begin
            if (period_q == '0) period_q = DefaultPeriod;
            ph_q = PhChunkHead;
            pending_results.push_back(stamp_result(KindHeader, 8'h00, 1'b0, 24'd0));
          end
        end
      end
      PhChunkHead: begin
        if (pos < 4) tag_q = {tag_q[23:0], b};
        else if (pos == 4) size_q = {24'd0, b};
        else size_q[8 * (pos - 4) +: 8] = b;
        if (pos < 7) begin
          pos_q = pos + 1;
        end else begin
          pos_q = '0;
          if (tag_q == VideoTag && size_q <= {8'd0, max_q}) begin
            if (size_q == '0) begin
              pending_results.push_back(stamp_result(KindEmpty, 8'h00, 1'b1, 24'd0));
              frames_q++;
            end else begin
              ph_q = PhData;
            end
          end else if (size_q != '0) begin
            ph_q = PhSkip;
          end
        end
      end
      PhData: begin
        last = (pos + 1 == size_q);
        pending_results.push_back(stamp_result(KindData, b, last, size_q[23:0]));
        if (last) begin
          frames_q++;
          finish_chunk_body();
        end else begin
          pos_q = pos + 1;
        end
      end
      PhSkip: begin
        if ({1'b0, pos} + 33'd1 >= {1'b0, size_q}) finish_chunk_body();
        else pos_q = pos + 1;
      end
      PhPad: begin
        pos_q = '0;
        ph_q  = PhChunkHead;
      end
      default: ;
    endcase
  endfunction

  // Sender: called just after a falling edge, returns just after one
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    byte_if.valid       <= 1'b1;
    byte_if.stream_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    parse_stream_byte(b);
    burst_left--;
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_chunk_head(input logic [31:0] tag, input logic [31:0] size);
    for (int i = 3; i >= 0; i--) send_byte(tag[8 * i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(size[8 * i +: 8]);
  endtask

  // Header, random body, and pad byte when the size is odd
  task automatic send_chunk(input logic [31:0] tag, input logic [31:0] size);
    send_chunk_head(tag, size);
    repeat (size) send_byte(8'($urandom_range(0, 255)));
    if (size[0]) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Hold the input idle until every item is out and the pipeline is empty
  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_frame_limit(input logic [23:0] limit);
    cfg_if.valid           <= 1'b1;
    cfg_if.max_frame_bytes <= limit;
    do @(posedge clk_i); while (!cfg_if.ready);
    max_q = limit;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // A malformed magic halts parsing until reset, so the run keeps one good header
  task automatic test_header_latch();
    logic [7:0]  hdr [HeaderBytesDefault];
    logic [31:0] total, width, height;
    total  = $urandom;
    width  = $urandom;
    height = $urandom;
    for (int i = 0; i < HeaderBytesDefault; i++) hdr[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 4; i++) begin
      hdr[i]              = RiffTag[31 - 8 * i -: 8];
      hdr[8 + i]          = AviTag[31 - 8 * i -: 8];
      hdr[PeriodBase + i] = 8'h00;
      hdr[TotalBase + i]  = total[8 * i +: 8];
      hdr[WidthBase + i]  = width[8 * i +: 8];
      hdr[HeightBase + i] = height[8 * i +: 8];
    end
    for (int i = 0; i < HeaderBytesDefault; i++) send_byte(hdr[i]);
    wait_idle();
  endtask

  task automatic test_frame_shapes();
    send_chunk_head(VideoTag, 32'd0);
    send_chunk_head(VideoTag, 32'd1);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_chunk_head(VideoTag, 32'd3);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hAA);
    send_chunk(AudioTag, 32'd5);
    send_chunk(JunkTag, 32'd0);
    send_chunk(RawVideoTag, 32'd2);
    wait_idle();
  endtask

  task automatic test_frame_limit();
    write_frame_limit(24'd0);
    send_chunk(VideoTag, 32'd1);
    send_chunk(VideoTag, 32'd0);
    wait_idle();
    write_frame_limit(24'd4);
    send_chunk(VideoTag, 32'd4);
    send_chunk(VideoTag, 32'd5);
    wait_idle();
  endtask

  task automatic send_random_chunks(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] tag;
    logic [31:0] size;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        tag = VideoTag;
        if (pick < 10 && max_q < 64) size = max_q + $urandom_range(0, 1);
        else if (pick < 17) size = $urandom_range(25, 120);
        else size = $urandom_range(0, 24);
      end else begin
        case ($urandom_range(0, 5))
          0: tag = AudioTag;
          1: tag = IndexTag;
          2: tag = JunkTag;
          3: tag = RawVideoTag;
          4: tag = VideoTag ^ (32'd1 << $urandom_range(0, 31));
          default: tag = $urandom;
        endcase
        size = $urandom_range(0, 40);
      end
      send_chunk(tag, size);
    end
  endtask

  task automatic test_random_stream();
    logic [23:0] limits [4];
    limits[0] = 24'd8;
    limits[1] = 24'($urandom_range(0, 40));
    limits[2] = MaxFrameTop;
    limits[3] = MaxFrameReset;
    foreach (limits[i]) begin
      write_frame_limit(limits[i]);
      send_random_chunks(200);
      wait_idle();
    end
  endtask

  // Frame cut off by the end of the stream: payload never gets its last flag
  task automatic test_truncated_frame();
    write_frame_limit(MaxFrameTop);
    send_chunk_head(VideoTag, {8'd0, MaxFrameTop});
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  // Receiver stall pattern: switch between open, random, choked and periodic
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 150);
      end
      case (mode)
        0: result_if.ready <= 1'b1;
        1: result_if.ready <= 1'($urandom_range(0, 1));
        2: result_if.ready <= ($urandom_range(0, 3) == 0);
        default: result_if.ready <= tick[2];
      endcase
      mode_left--;
      tick++;
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, kind expected none actual %0d", $time,
                 result_if.result_kind);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_if.result_kind));
        check_field("payload_byte", 32'(want.data), 32'(result_if.payload_byte));
        check_field("frame_last", 32'(want.last), 32'(result_if.frame_last));
        check_field("frame_length", 32'(want.length), 32'(result_if.frame_length));
        check_field("frame_number", want.number, result_if.frame_number);
        check_field("frame_period_us", want.period, result_if.frame_period_us);
        check_field("frame_total", want.total, result_if.frame_total);
        check_field("picture_width", want.width, result_if.picture_width);
        check_field("picture_height", want.height, result_if.picture_height);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni                 = 1'b0;
    byte_if.valid          = 1'b0;
    byte_if.stream_byte    = 8'h00;
    cfg_if.valid           = 1'b0;
    cfg_if.max_frame_bytes = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_header_latch();
    test_frame_shapes();
    test_frame_limit();
    test_random_stream();
    test_truncated_frame();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/avi_ce_pkg.sv
design/avi_ce_if.sv
design/avi_ce_in_reg.sv
design/avi_ce_parser.sv
design/avi_video_chunk_extractor_unit.sv
test/avi_video_chunk_extractor_unit_test.sv
